// ===== rtl/aes_ctr_pkg.sv =====
package aes_ctr_pkg;

	localparam int NumRounds = 10;
	localparam int BlockW = 128;

	localparam logic [1:0] RegKeyHigh = 2'd0;
	localparam logic [1:0] RegKeyLow = 2'd1;
	localparam logic [1:0] RegNonceHigh = 2'd2;
	localparam logic [1:0] RegNonceLow = 2'd3;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [11] = '{
		8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a block sits in bits 127-8i .. 120-8i.
	function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
		get_byte = b[127 - 8*i -: 8];
	endfunction

	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
			end
		end
		sub_shift = t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, all;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, c*4);
			a1 = get_byte(s, c*4+1);
			a2 = get_byte(s, c*4+2);
			a3 = get_byte(s, c*4+3);
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 8*(c*4) -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[127 - 8*(c*4+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[127 - 8*(c*4+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[127 - 8*(c*4+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		mix_cols = t;
	endfunction

	// Next round key from the previous one.
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		next_key = {w0, w1, w2, w3};
	endfunction

endpackage

// ===== rtl/aes_ctr_round.sv =====
module aes_ctr_round #(
	parameter int Round = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         vld_in,
	input  logic [127:0] state_in,
	input  logic [127:0] rkey_in,
	input  logic [127:0] pay_in,
	output logic         vld_out,
	output logic [127:0] state_out,
	output logic [127:0] rkey_out,
	output logic [127:0] pay_out
);

	logic [127:0] nkey;
	logic [127:0] mixed;

	// Each cell derives its own round key on the fly from the key it received.
	always_comb begin
		nkey = aes_ctr_pkg::next_key(rkey_in, aes_ctr_pkg::RCON[Round]);
		if (Round == aes_ctr_pkg::NumRounds) begin
			mixed = aes_ctr_pkg::sub_shift(state_in);
		end else begin
			mixed = aes_ctr_pkg::mix_cols(aes_ctr_pkg::sub_shift(state_in));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (adv) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			state_out <= mixed ^ nkey;
			rkey_out <= nkey;
			pay_out <= pay_in;
		end
	end

endmodule

// ===== rtl/aes128_ctr_payload_cipher_top.sv =====
// An accepted item passes the key-add stage and then the ten round cells in turn.
// Throughput: one item per cycle through this chain while the output is not stalled.
// The whole chain advances together and holds while the output is stalled with a result.
// Reset (arst_n low) clears all configuration registers to zero and empties the chain.
module aes128_ctr_payload_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] payload_high,
	input  logic [63:0] payload_low,
	input  logic [14:0] frame_number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);

	localparam int N = aes_ctr_pkg::NumRounds;

	logic [63:0] key_high_q, key_low_q, nonce_high_q;
	logic [47:0] nonce_low_q;
	logic [1:0]  reg_idx;
	logic        adv;

	logic         vld [N+1];
	logic [127:0] st [N+1];
	logic [127:0] rk [N+1];
	logic [127:0] pay [N+1];

	assign pready = 1'b1;
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			nonce_high_q <= '0;
			nonce_low_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				aes_ctr_pkg::RegKeyHigh: key_high_q <= pwdata;
				aes_ctr_pkg::RegKeyLow: key_low_q <= pwdata;
				aes_ctr_pkg::RegNonceHigh: nonce_high_q <= pwdata;
				aes_ctr_pkg::RegNonceLow: nonce_low_q <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			aes_ctr_pkg::RegKeyHigh: prdata = key_high_q;
			aes_ctr_pkg::RegKeyLow: prdata = key_low_q;
			aes_ctr_pkg::RegNonceHigh: prdata = nonce_high_q;
			aes_ctr_pkg::RegNonceLow: prdata = {16'h0, nonce_low_q};
			default: prdata = '0;
		endcase
	end

	// The chain moves unless a finished result is being held.
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// First stage: initial key add on the counter block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (adv) begin
			vld[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st[0] <= {nonce_high_q, nonce_low_q, 1'b0, frame_number}
				^ {key_high_q, key_low_q};
			rk[0] <= {key_high_q, key_low_q};
			pay[0] <= {payload_high, payload_low};
		end
	end

	for (genvar g = 1; g <= N; g++) begin : g_cell
		aes_ctr_round #(.Round(g)) u_round (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.vld_in(vld[g-1]),
			.state_in(st[g-1]),
			.rkey_in(rk[g-1]),
			.pay_in(pay[g-1]),
			.vld_out(vld[g]),
			.state_out(st[g]),
			.rkey_out(rk[g]),
			.pay_out(pay[g])
		);
	end

	assign out_valid = vld[N];
	assign cipher_high = st[N][127:64] ^ pay[N][127:64];
	assign cipher_low = st[N][63:0] ^ pay[N][63:0];

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
		else $error("result changed while stalled");
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !vld[N-1] |=> !out_valid)
		else $error("result appeared from empty stage");
`endif

endmodule
